// ===== rtl/phfe_pkg.sv =====
package phfe_pkg;

  localparam int MAX_FRAME = 65535;

  // Link framing codes held in the configuration register.
  localparam logic [1:0] LINK_ETHERNET = 2'd0;
  localparam logic [1:0] LINK_COOKED   = 2'd1;
  localparam logic [1:0] LINK_RAW      = 2'd2;
  localparam logic [1:0] LINK_NONE     = 2'd3;

  // Record status codes.
  localparam logic [1:0] ST_PARSED    = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_UNPARSED  = 2'd2;

  localparam logic [2:0] IPVER_NONE = 3'd0;
  localparam logic [2:0] IPVER_4    = 3'd4;
  localparam logic [2:0] IPVER_6    = 3'd6;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
  localparam logic [3:0]  VERSION_4 = 4'd4;
  localparam logic [3:0]  VERSION_6 = 4'd6;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_word_t;

  typedef struct packed {
    logic [1:0]  parse_status;
    logic [2:0]  l3_version;
    logic [7:0]  l4_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [5:0]  tcp_flag_bits;
    logic [31:0] tcp_sequence;
    logic [31:0] tcp_acknowledge;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } record_word_t;

  // Everything captured from one frame, handed from the parser to the record builder.
  typedef struct packed {
    logic [1:0]  link_type;
    logic [15:0] byte_count;
    logic [15:0] l3_type;
    logic [5:0]  ip_hdr_bytes;
    logic [5:0]  l4_hdr_bytes;
    logic [63:0] addr_cap;
    logic [63:0] seq_cap;
    logic [31:0] port_cap;
    logic [7:0]  v4_proto;
    logic [7:0]  v6_next;
    logic [5:0]  flag_cap;
  } frame_state_t;

  function automatic logic [4:0] link_hdr_len(input logic [1:0] lt);
    logic [4:0] len;
    unique case (lt)
      LINK_ETHERNET: len = 5'd14;
      LINK_COOKED:   len = 5'd16;
      default:       len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/phfe_parser.sv =====
module phfe_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            link_type,
  input  logic                  frame_valid,
  output logic                  frame_stall,
  input  phfe_pkg::frame_word_t frame_data,
  output logic                  snap_valid,
  input  logic                  snap_take,
  output phfe_pkg::frame_state_t snap
);

  logic                   word_valid;
  phfe_pkg::frame_word_t  word;
  logic                   active;
  logic                   take;

  logic [15:0] position, position_next;
  logic [15:0] l3_type, l3_type_next;
  logic [5:0]  ip_hdr_bytes, ip_hdr_bytes_next;
  logic [6:0]  l4_start, l4_start_next;
  logic [5:0]  l4_hdr_bytes, l4_hdr_bytes_next;
  logic [63:0] addr_cap, addr_cap_next;
  logic [63:0] seq_cap, seq_cap_next;
  logic [31:0] port_cap, port_cap_next;
  logic [7:0]  v4_proto, v4_proto_next;
  logic [7:0]  v6_next, v6_next_next;
  logic [5:0]  flag_cap, flag_cap_next;

  logic [4:0]  hl;
  logic [15:0] rel;
  logic [15:0] r4;
  logic [7:0]  b;
  phfe_pkg::frame_state_t snap_next;

  // A last word may only be consumed when the snapshot slot is free or draining.
  assign active      = word_valid && (!word.last_byte || !snap_valid || snap_take);
  assign frame_stall = word_valid && !active;
  assign take        = frame_valid && !frame_stall;

  always_comb begin
    hl                = phfe_pkg::link_hdr_len(link_type);
    b                 = word.frame_byte;
    rel               = position - 16'(hl);
    r4                = position - 16'(l4_start);
    position_next     = position;
    l3_type_next      = l3_type;
    ip_hdr_bytes_next = ip_hdr_bytes;
    l4_start_next     = l4_start;
    l4_hdr_bytes_next = l4_hdr_bytes;
    addr_cap_next     = addr_cap;
    seq_cap_next      = seq_cap;
    port_cap_next     = port_cap;
    v4_proto_next     = v4_proto;
    v6_next_next      = v6_next;
    flag_cap_next     = flag_cap;

    // Bytes past the capture limit are neither counted nor parsed.
    if (position < 16'(phfe_pkg::MAX_FRAME)) begin
      position_next = position + 16'd1;
      if (link_type != phfe_pkg::LINK_NONE) begin
        if (link_type != phfe_pkg::LINK_RAW &&
            (position == 16'(hl) - 16'd2 || position == 16'(hl) - 16'd1)) begin
          l3_type_next = {l3_type[7:0], b};
        end
        if (position >= 16'(hl)) begin
          if (rel == 16'd0) begin
            ip_hdr_bytes_next = {b[3:0], 2'b00};
            l4_start_next     = (b[3:0] >= 4'd5) ? 7'(hl) + {1'b0, b[3:0], 2'b00} : 7'd0;
            if (link_type == phfe_pkg::LINK_RAW) begin
              if (b[7:4] == phfe_pkg::VERSION_4) begin
                l3_type_next = phfe_pkg::TYPE_IPV4;
              end else if (b[7:4] == phfe_pkg::VERSION_6) begin
                l3_type_next = phfe_pkg::TYPE_IPV6;
              end else begin
                l3_type_next = 16'd0;
              end
            end
          end else if (rel == 16'd6) begin
            v6_next_next = b;
          end else if (rel == 16'd9) begin
            v4_proto_next = b;
          end else if (rel >= 16'd12 && rel <= 16'd19) begin
            addr_cap_next = {addr_cap[55:0], b};
          end

          // The L4 start written on the first L3 byte always lies beyond that byte.
          if (l4_start != 7'd0 && position >= 16'(l4_start)) begin
            if (r4 <= 16'd3) begin
              port_cap_next = {port_cap[23:0], b};
            end else if (r4 <= 16'd11) begin
              seq_cap_next = {seq_cap[55:0], b};
            end else if (r4 == 16'd12) begin
              l4_hdr_bytes_next = {b[7:4], 2'b00};
            end else if (r4 == 16'd13) begin
              flag_cap_next = b[5:0];
            end
          end
        end
      end
    end

    snap_next.link_type    = link_type;
    snap_next.byte_count   = position_next;
    snap_next.l3_type      = l3_type_next;
    snap_next.ip_hdr_bytes = ip_hdr_bytes_next;
    snap_next.l4_hdr_bytes = l4_hdr_bytes_next;
    snap_next.addr_cap     = addr_cap_next;
    snap_next.seq_cap      = seq_cap_next;
    snap_next.port_cap     = port_cap_next;
    snap_next.v4_proto     = v4_proto_next;
    snap_next.v6_next      = v6_next_next;
    snap_next.flag_cap     = flag_cap_next;
  end

  // The whole frame state clears as the last word moves into the snapshot.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid   <= 1'b0;
      snap_valid   <= 1'b0;
      position     <= 16'd0;
      l3_type      <= 16'd0;
      ip_hdr_bytes <= 6'd0;
      l4_start     <= 7'd0;
      l4_hdr_bytes <= 6'd0;
      addr_cap     <= 64'd0;
      seq_cap      <= 64'd0;
      port_cap     <= 32'd0;
      v4_proto     <= 8'd0;
      v6_next      <= 8'd0;
      flag_cap     <= 6'd0;
    end else begin
      if (take) begin
        word_valid <= 1'b1;
      end else if (active) begin
        word_valid <= 1'b0;
      end
      if (active && word.last_byte) begin
        snap_valid <= 1'b1;
      end else if (snap_take) begin
        snap_valid <= 1'b0;
      end
      if (active) begin
        if (word.last_byte) begin
          position     <= 16'd0;
          l3_type      <= 16'd0;
          ip_hdr_bytes <= 6'd0;
          l4_start     <= 7'd0;
          l4_hdr_bytes <= 6'd0;
          addr_cap     <= 64'd0;
          seq_cap      <= 64'd0;
          port_cap     <= 32'd0;
          v4_proto     <= 8'd0;
          v6_next      <= 8'd0;
          flag_cap     <= 6'd0;
        end else begin
          position     <= position_next;
          l3_type      <= l3_type_next;
          ip_hdr_bytes <= ip_hdr_bytes_next;
          l4_start     <= l4_start_next;
          l4_hdr_bytes <= l4_hdr_bytes_next;
          addr_cap     <= addr_cap_next;
          seq_cap      <= seq_cap_next;
          port_cap     <= port_cap_next;
          v4_proto     <= v4_proto_next;
          v6_next      <= v6_next_next;
          flag_cap     <= flag_cap_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word <= frame_data;
    end
    if (active && word.last_byte) begin
      snap <= snap_next;
    end
  end

endmodule

// ===== rtl/phfe_record.sv =====
module phfe_record (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   snap_valid,
  input  phfe_pkg::frame_state_t snap,
  output logic                   snap_take,
  output logic                   record_valid,
  input  logic                   record_stall,
  output phfe_pkg::record_word_t record_data
);

  logic                   load;
  phfe_pkg::record_word_t rec;
  logic [4:0]             hl;
  logic [15:0]            n;
  logic [7:0]             l4_off;
  logic [7:0]             v4_min;
  logic [7:0]             tcp_min;
  logic [7:0]             tcp_end;
  logic [7:0]             udp_end;

  assign load      = !record_valid || !record_stall;
  assign snap_take = snap_valid && load;

  // Every byte-count test is a compare against a small header end; header lengths are checked against their minimum.
  always_comb begin
    hl      = phfe_pkg::link_hdr_len(snap.link_type);
    n       = snap.byte_count;
    l4_off  = 8'(hl) + 8'(snap.ip_hdr_bytes);
    v4_min  = 8'(hl) + 8'd20;
    tcp_min = l4_off + 8'd20;
    tcp_end = l4_off + 8'(snap.l4_hdr_bytes);
    udp_end = l4_off + 8'd8;
    rec     = '0;

    if (snap.link_type == phfe_pkg::LINK_NONE) begin
      rec.parse_status = phfe_pkg::ST_UNPARSED;
    end else if (n < 16'(hl)) begin
      rec.parse_status = phfe_pkg::ST_TRUNCATED;
    end else begin
      rec.parse_status = phfe_pkg::ST_PARSED;
      if (snap.l3_type == phfe_pkg::TYPE_IPV4 && n >= 16'(v4_min)) begin
        rec.l3_version     = phfe_pkg::IPVER_4;
        rec.l4_protocol    = snap.v4_proto;
        rec.source_address = snap.addr_cap[63:32];
        rec.dest_address   = snap.addr_cap[31:0];
        if (snap.ip_hdr_bytes >= 6'd20 && n >= 16'(l4_off)) begin
          if (snap.v4_proto == phfe_pkg::PROTO_TCP && n >= 16'(tcp_min)) begin
            rec.source_port     = snap.port_cap[31:16];
            rec.dest_port       = snap.port_cap[15:0];
            rec.tcp_flag_bits   = snap.flag_cap;
            rec.tcp_sequence    = snap.seq_cap[63:32];
            rec.tcp_acknowledge = snap.seq_cap[31:0];
            if (snap.l4_hdr_bytes >= 6'd20 && n >= 16'(tcp_end)) begin
              rec.payload_offset = 16'(tcp_end);
              rec.payload_length = n - 16'(tcp_end);
            end
          end else if (snap.v4_proto == phfe_pkg::PROTO_UDP && n >= 16'(udp_end)) begin
            rec.source_port    = snap.port_cap[31:16];
            rec.dest_port      = snap.port_cap[15:0];
            rec.payload_offset = 16'(udp_end);
            rec.payload_length = n - 16'(udp_end);
          end
        end
      end else if (snap.l3_type == phfe_pkg::TYPE_IPV6 &&
                   n >= 16'(hl) + 16'd40) begin
        rec.l3_version  = phfe_pkg::IPVER_6;
        rec.l4_protocol = snap.v6_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
    end else if (load) begin
      record_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      record_data <= rec;
    end
  end

endmodule

// ===== rtl/packet_header_field_extractor.sv =====
// Accepts one frame word per cycle with no bubbles while frame_stall is low; the single parse
// state is updated once per byte, so throughput is one byte per cycle when no stall holds the input.
// After its last byte is accepted, a frame's record passes through the frame snapshot register,
// then the result register, before it is valid; a receiver stall can hold it in either.
// Reset (rst, synchronous) empties all three stages, clears the frame state and sets
// the link type to Ethernet.
module packet_header_field_extractor (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_wdata,
  input  logic                   frame_valid,
  output logic                   frame_stall,
  input  phfe_pkg::frame_word_t  frame_data,
  output logic                   record_valid,
  input  logic                   record_stall,
  output phfe_pkg::record_word_t record_data
);

  logic [1:0]             link_type;
  logic                   snap_valid;
  logic                   snap_take;
  phfe_pkg::frame_state_t snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_type <= phfe_pkg::LINK_ETHERNET;
    end else if (cfg_we) begin
      link_type <= cfg_wdata;
    end
  end

  phfe_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .link_type   (link_type),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_data  (frame_data),
    .snap_valid  (snap_valid),
    .snap_take   (snap_take),
    .snap        (snap)
  );

  phfe_record u_record (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap         (snap),
    .snap_take    (snap_take),
    .record_valid (record_valid),
    .record_stall (record_stall),
    .record_data  (record_data)
  );

  // A waiting snapshot is neither dropped nor overwritten.
  a_snap_held: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_take |=> snap_valid && $stable(snap))
    else $error("frame snapshot lost or changed while waiting");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    record_valid && record_data.parse_status != phfe_pkg::ST_PARSED |->
      record_data.l3_version == phfe_pkg::IPVER_NONE && record_data.payload_length == 16'd0)
    else $error("fields set on a record that was not parsed");

  a_payload_v4: assert property (@(posedge clk) disable iff (rst)
    record_valid && record_data.payload_offset != 16'd0 |->
      record_data.l3_version == phfe_pkg::IPVER_4)
    else $error("payload reported without an IPv4 header");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> snap_valid && !snap_take)
    else $error("input stalled while the snapshot slot was free");

endmodule

// ===== bench/packet_header_field_extractor_tb.sv =====
`timescale 1ns / 1ps

module packet_header_field_extractor_tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;

  localparam int L3_IPV4 = 0;
  localparam int L3_IPV6 = 1;
  localparam int L3_OTHER = 2;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZEROS = 1;
  localparam int FILL_ONES = 2;

  localparam logic [15:0] TYPE_ARP = 16'h0806;
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_wdata;
  logic frame_valid;
  logic frame_stall;
  phfe_pkg::frame_word_t frame_data;
  logic record_valid;
  logic record_stall;
  phfe_pkg::record_word_t record_data;

  packet_header_field_extractor dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame_data(frame_data),
    .record_valid(record_valid),
    .record_stall(record_stall),
    .record_data(record_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus controls shared between the sender, the receiver and the tests.
  bit source_idle;
  bit sink_idle;
  int hold_request;
  int fill_mode;
  int mismatches;
  logic [7:0] frame_q[$];
  phfe_pkg::record_word_t pending_records[$];

  // Parser state as the block should hold it.
  logic [1:0] link_sel;
  int unsigned byte_cnt;
  logic [15:0] net_type;
  logic [5:0] ip_hlen;
  int unsigned l4_base;
  logic [5:0] l4_hlen;
  logic [63:0] addr_pair;
  logic [63:0] seqack_pair;
  logic [31:0] port_pair;
  logic [7:0] v4_proto;
  logic [7:0] v6_next;
  logic [5:0] flags_cap;

  function automatic int unsigned framing_len(input logic [1:0] lt);
    case (lt)
      phfe_pkg::LINK_ETHERNET: return 14;
      phfe_pkg::LINK_COOKED: return 16;
      default: return 0;
    endcase
  endfunction

  function automatic void clear_frame_state();
    byte_cnt = 0;
    net_type = '0;
    ip_hlen = '0;
    l4_base = 0;
    l4_hlen = '0;
    addr_pair = '0;
    seqack_pair = '0;
    port_pair = '0;
    v4_proto = '0;
    v6_next = '0;
    flags_cap = '0;
  endfunction

  function automatic phfe_pkg::record_word_t header_record();
    phfe_pkg::record_word_t r;
    int unsigned hl, l3len, l4len, l4off, th;
    r = '0;
    hl = framing_len(link_sel);
    if (link_sel == phfe_pkg::LINK_NONE) begin
      r.parse_status = phfe_pkg::ST_UNPARSED;
    end else if (byte_cnt < hl) begin
      r.parse_status = phfe_pkg::ST_TRUNCATED;
    end else begin
      r.parse_status = phfe_pkg::ST_PARSED;
      l3len = byte_cnt - hl;
      if (net_type == phfe_pkg::TYPE_IPV4 && l3len >= 20) begin
        r.l3_version = phfe_pkg::IPVER_4;
        r.l4_protocol = v4_proto;
        r.source_address = addr_pair[63:32];
        r.dest_address = addr_pair[31:0];
        // A header length shorter than the minimum or past the capture means no transport.
        if (ip_hlen >= 20 && 32'(ip_hlen) <= l3len) begin
          l4len = l3len - 32'(ip_hlen);
          l4off = hl + 32'(ip_hlen);
          if (v4_proto == phfe_pkg::PROTO_TCP && l4len >= 20) begin
            r.source_port = port_pair[31:16];
            r.dest_port = port_pair[15:0];
            r.tcp_flag_bits = flags_cap;
            r.tcp_sequence = seqack_pair[63:32];
            r.tcp_acknowledge = seqack_pair[31:0];
            th = 32'(l4_hlen);
            if (th >= 20 && th <= l4len) begin
              r.payload_offset = 16'(l4off + th);
              r.payload_length = 16'(l4len - th);
            end
          end else if (v4_proto == phfe_pkg::PROTO_UDP && l4len >= 8) begin
            r.source_port = port_pair[31:16];
            r.dest_port = port_pair[15:0];
            r.payload_offset = 16'(l4off + 8);
            r.payload_length = 16'(l4len - 8);
          end
        end
      end else if (net_type == phfe_pkg::TYPE_IPV6 && l3len >= 40) begin
        r.l3_version = phfe_pkg::IPVER_6;
        r.l4_protocol = v6_next;
      end
    end
    return r;
  endfunction

  task automatic advance_header_parse(input logic [7:0] b, input logic last);
    int unsigned hl, pos, rel, r4;
    hl = framing_len(link_sel);
    // Bytes past the longest frame are neither counted nor parsed.
    if (byte_cnt < phfe_pkg::MAX_FRAME) begin
      pos = byte_cnt;
      byte_cnt++;
      if (link_sel != phfe_pkg::LINK_NONE) begin
        if (link_sel != phfe_pkg::LINK_RAW && (pos + 2 == hl || pos + 1 == hl))
          net_type = {net_type[7:0], b};
        if (pos >= hl) begin
          rel = pos - hl;
          if (rel == 0) begin
            ip_hlen = {b[3:0], 2'b00};
            l4_base = (b[3:0] >= 4'd5) ? hl + 32'(b[3:0]) * 4 : 0;
            if (link_sel == phfe_pkg::LINK_RAW) begin
              if (b[7:4] == phfe_pkg::VERSION_4) net_type = phfe_pkg::TYPE_IPV4;
              else if (b[7:4] == phfe_pkg::VERSION_6) net_type = phfe_pkg::TYPE_IPV6;
              else net_type = '0;
            end
          end else if (rel == 6) begin
            v6_next = b;
          end else if (rel == 9) begin
            v4_proto = b;
          end else if (rel >= 12 && rel <= 19) begin
            addr_pair = {addr_pair[55:0], b};
          end
          if (l4_base != 0 && pos >= l4_base) begin
            r4 = pos - l4_base;
            if (r4 <= 3) port_pair = {port_pair[23:0], b};
            else if (r4 <= 11) seqack_pair = {seqack_pair[55:0], b};
            else if (r4 == 12) l4_hlen = {b[7:4], 2'b00};
            else if (r4 == 13) flags_cap = b[5:0];
          end
        end
      end
    end
    if (last) begin
      pending_records.push_back(header_record());
      clear_frame_state();
    end
  endtask

  function automatic logic [7:0] fill_byte();
    case (fill_mode)
      FILL_ZEROS: return 8'h00;
      FILL_ONES: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Builds a frame in frame_q; keep, when nonzero, cuts the capture to that many bytes.
  task automatic build_frame(input logic [1:0] link, input int l3kind, input int ihl,
                             input logic [7:0] proto, input int doff, input int body_len,
                             input int keep);
    logic [15:0] tag;
    logic [7:0] x;
    logic [3:0] ihl_n, doff_n;
    int k;
    ihl_n = 4'(ihl);
    doff_n = 4'(doff);
    frame_q.delete();
    if (link == phfe_pkg::LINK_ETHERNET || link == phfe_pkg::LINK_COOKED) begin
      repeat (link == phfe_pkg::LINK_ETHERNET ? 12 : 14) frame_q.push_back(fill_byte());
      if (l3kind == L3_IPV4) tag = phfe_pkg::TYPE_IPV4;
      else if (l3kind == L3_IPV6) tag = phfe_pkg::TYPE_IPV6;
      else if ($urandom_range(0, 1) == 0) tag = TYPE_ARP;
      else tag = 16'($urandom_range(0, 65535));
      frame_q.push_back(tag[15:8]);
      frame_q.push_back(tag[7:0]);
    end
    if (l3kind == L3_IPV4) begin
      frame_q.push_back({phfe_pkg::VERSION_4, ihl_n});
      for (k = 1; k < 20; k++) frame_q.push_back(k == 9 ? proto : fill_byte());
      if (ihl > 5) repeat ((ihl - 5) * 4) frame_q.push_back(fill_byte());
      if (proto == phfe_pkg::PROTO_TCP) begin
        repeat (12) frame_q.push_back(fill_byte());
        x = fill_byte();
        frame_q.push_back({doff_n, x[3:0]});
        repeat (7) frame_q.push_back(fill_byte());
        if (doff > 5) repeat ((doff - 5) * 4) frame_q.push_back(fill_byte());
      end else if (proto == phfe_pkg::PROTO_UDP) begin
        repeat (8) frame_q.push_back(fill_byte());
      end
    end else if (l3kind == L3_IPV6) begin
      x = fill_byte();
      frame_q.push_back({phfe_pkg::VERSION_6, x[3:0]});
      repeat (39) frame_q.push_back(fill_byte());
    end else begin
      frame_q.push_back(fill_byte());
    end
    repeat (body_len) frame_q.push_back(fill_byte());
    if (keep > 0 && keep < frame_q.size()) frame_q = frame_q[0:keep-1];
  endtask

  task automatic build_noise(input int len);
    frame_q.delete();
    repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_word(input logic [7:0] b, input logic last);
    phfe_pkg::frame_word_t w;
    int gap;
    w.frame_byte = b;
    w.last_byte = last;
    gap = 0;
    if (source_idle && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 5);
    @(negedge clk);
    if (gap > 0) begin
      frame_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_valid <= 1'b1;
    frame_data <= w;
    do @(posedge clk); while (frame_stall !== 1'b0);
    advance_header_parse(b, last);
  endtask

  task automatic send_span(input int first, input int stop);
    int k;
    for (k = first; k < stop; k++) send_word(frame_q[k], k == frame_q.size() - 1);
  endtask

  // Lets every outstanding record come out, then gives the pipeline time to empty.
  task automatic settle();
    @(negedge clk);
    frame_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_link_type(input logic [1:0] lt);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lt;
    @(posedge clk);
    link_sel = lt;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : record_check
    phfe_pkg::record_word_t want;
    if (!rst && record_valid && !record_stall) begin
      if (pending_records.size() == 0) begin
        $error("record word with no frame outstanding: 0x%0h", record_data);
        mismatches++;
      end else begin
        want = pending_records[0];
        pending_records.delete(0);
        check_field("parse_status", 32'(want.parse_status), 32'(record_data.parse_status));
        check_field("l3_version", 32'(want.l3_version), 32'(record_data.l3_version));
        check_field("l4_protocol", 32'(want.l4_protocol), 32'(record_data.l4_protocol));
        check_field("source_address", want.source_address, record_data.source_address);
        check_field("dest_address", want.dest_address, record_data.dest_address);
        check_field("source_port", 32'(want.source_port), 32'(record_data.source_port));
        check_field("dest_port", 32'(want.dest_port), 32'(record_data.dest_port));
        check_field("tcp_flag_bits", 32'(want.tcp_flag_bits),
                    32'(record_data.tcp_flag_bits));
        check_field("tcp_sequence", want.tcp_sequence, record_data.tcp_sequence);
        check_field("tcp_acknowledge", want.tcp_acknowledge, record_data.tcp_acknowledge);
        check_field("payload_offset", 32'(want.payload_offset),
                    32'(record_data.payload_offset));
        check_field("payload_length", 32'(want.payload_length),
                    32'(record_data.payload_length));
      end
    end
  end

  // Receiver: short random stall bursts, or one long hold when a test asks for it.
  initial begin : record_sink
    int n;
    record_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        record_stall <= 1'b1;
        repeat (n) @(negedge clk);
        record_stall <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        record_stall <= 1'b1;
        repeat (n) @(negedge clk);
        record_stall <= 1'b0;
      end else begin
        record_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (frame_valid && !frame_stall) || (record_valid && !record_stall)) quiet = 0;
      else quiet++;
    end
    $display("packet_header_field_extractor regression: fail");
    $finish;
  end

  task automatic test_link_framing();
    logic [1:0] lt;
    int k;
    for (k = 0; k < 4; k++) begin
      lt = 2'(k);
      set_link_type(lt);
      build_frame(lt, L3_IPV4, 5, phfe_pkg::PROTO_TCP, 5, 6, 0);
      send_span(0, frame_q.size());
      build_frame(lt, L3_OTHER, 5, phfe_pkg::PROTO_TCP, 5, 0, 1);
      send_span(0, frame_q.size());
      // Captures one byte short of the link header and exactly the link header.
      if (lt == phfe_pkg::LINK_ETHERNET || lt == phfe_pkg::LINK_COOKED) begin
        build_frame(lt, L3_OTHER, 5, phfe_pkg::PROTO_TCP, 5, 4, framing_len(lt) - 1);
        send_span(0, frame_q.size());
        build_frame(lt, L3_OTHER, 5, phfe_pkg::PROTO_TCP, 5, 4, framing_len(lt));
        send_span(0, frame_q.size());
      end
    end
  endtask

  task automatic test_ipv4_transport();
    set_link_type(phfe_pkg::LINK_ETHERNET);
    // All-ones bytes: every flag set and the largest TCP header.
    fill_mode = FILL_ONES;
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 5, phfe_pkg::PROTO_TCP, 15, 0, 0);
    send_span(0, frame_q.size());
    fill_mode = FILL_ZEROS;
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 5, phfe_pkg::PROTO_TCP, 5, 3, 0);
    send_span(0, frame_q.size());
    fill_mode = FILL_RANDOM;
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 5, phfe_pkg::PROTO_UDP, 5, 5, 0);
    send_span(0, frame_q.size());
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 5, PROTO_ICMP, 5, 12, 0);
    send_span(0, frame_q.size());
    // IP header length below the minimum.
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 4, phfe_pkg::PROTO_TCP, 5, 4, 0);
    send_span(0, frame_q.size());
    // IP header length that runs past the captured bytes.
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 15, phfe_pkg::PROTO_TCP, 5, 0, 44);
    send_span(0, frame_q.size());
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 6, phfe_pkg::PROTO_TCP, 4, 8, 0);
    send_span(0, frame_q.size());
    // TCP data offset longer than the capture keeps the TCP fields only.
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 5, phfe_pkg::PROTO_TCP, 15, 0, 74);
    send_span(0, frame_q.size());
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 5, phfe_pkg::PROTO_TCP, 5, 0, 53);
    send_span(0, frame_q.size());
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 5, phfe_pkg::PROTO_UDP, 5, 0, 41);
    send_span(0, frame_q.size());
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 5, phfe_pkg::PROTO_TCP, 5, 0, 33);
    send_span(0, frame_q.size());
  endtask

  task automatic test_ipv6_and_other_types();
    set_link_type(phfe_pkg::LINK_COOKED);
    build_frame(phfe_pkg::LINK_COOKED, L3_IPV6, 5, phfe_pkg::PROTO_TCP, 5, 3, 0);
    send_span(0, frame_q.size());
    build_frame(phfe_pkg::LINK_COOKED, L3_IPV6, 5, phfe_pkg::PROTO_TCP, 5, 0, 55);
    send_span(0, frame_q.size());
    build_frame(phfe_pkg::LINK_COOKED, L3_OTHER, 5, phfe_pkg::PROTO_TCP, 5, 27, 0);
    send_span(0, frame_q.size());
    set_link_type(phfe_pkg::LINK_RAW);
    build_frame(phfe_pkg::LINK_RAW, L3_IPV6, 5, phfe_pkg::PROTO_TCP, 5, 2, 0);
    send_span(0, frame_q.size());
    build_frame(phfe_pkg::LINK_RAW, L3_IPV4, 7, phfe_pkg::PROTO_UDP, 5, 9, 0);
    send_span(0, frame_q.size());
    build_frame(phfe_pkg::LINK_RAW, L3_OTHER, 5, phfe_pkg::PROTO_TCP, 5, 30, 0);
    send_span(0, frame_q.size());
  endtask

  // The link type is rewritten while a frame is half way in; later bytes use the new one.
  task automatic test_link_change_mid_frame();
    set_link_type(phfe_pkg::LINK_ETHERNET);
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 5, phfe_pkg::PROTO_UDP, 5, 6, 0);
    send_span(0, 10);
    set_link_type(phfe_pkg::LINK_COOKED);
    send_span(10, frame_q.size());
    build_frame(phfe_pkg::LINK_ETHERNET, L3_IPV4, 5, phfe_pkg::PROTO_TCP, 5, 6, 0);
    send_span(0, 20);
    set_link_type(phfe_pkg::LINK_RAW);
    send_span(20, frame_q.size());
  endtask

  // Many tiny frames while the receiver holds off, so the pipeline backs up into the input.
  task automatic test_output_hold();
    int k;
    set_link_type(phfe_pkg::LINK_ETHERNET);
    hold_request = HOLD_CYCLES;
    for (k = 0; k < 24; k++) begin
      build_noise($urandom_range(1, 4));
      send_span(0, frame_q.size());
    end
  endtask

  task automatic test_random_traffic();
    int phase, frames, sel, kind, ihl, doff, keep, r;
    logic [7:0] proto;
    logic [1:0] lt;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: lt = phfe_pkg::LINK_ETHERNET;
        1: lt = phfe_pkg::LINK_RAW;
        2: lt = phfe_pkg::LINK_COOKED;
        default: lt = ($urandom_range(0, 7) == 0) ? phfe_pkg::LINK_NONE
                                                  : 2'($urandom_range(0, 2));
      endcase
      set_link_type(lt);
      source_idle = (phase != 1) && (phase != 4);
      sink_idle = (phase != 2) && (phase != 4);
      for (frames = 0; frames < 2; frames++) begin
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
          build_noise($urandom_range(1, 24));
        end else begin
          kind = (sel < 65) ? L3_IPV4 : (sel < 82) ? L3_IPV6 : L3_OTHER;
          r = $urandom_range(0, 9);
          ihl = (r < 7) ? 5 : (r < 9) ? $urandom_range(6, 15) : $urandom_range(0, 4);
          r = $urandom_range(0, 9);
          doff = (r < 7) ? 5 : (r < 9) ? $urandom_range(6, 15) : $urandom_range(0, 4);
          r = $urandom_range(0, 99);
          proto = (r < 45) ? phfe_pkg::PROTO_TCP : (r < 80) ? phfe_pkg::PROTO_UDP
                                                            : 8'($urandom_range(0, 255));
          keep = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 70) : 0;
          build_frame(lt, kind, ihl, proto, doff, $urandom_range(0, 12), keep);
        end
        send_span(0, frame_q.size());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    frame_valid = 1'b0;
    frame_data = '0;
    source_idle = 1;
    sink_idle = 1;
    hold_request = 0;
    fill_mode = FILL_RANDOM;
    mismatches = 0;
    link_sel = phfe_pkg::LINK_ETHERNET;
    clear_frame_state();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_link_framing();
    test_ipv4_transport();
    test_ipv6_and_other_types();
    test_link_change_mid_frame();
    test_output_hold();
    test_random_traffic();

    settle();
    if (mismatches == 0) begin
      $display("packet_header_field_extractor regression: pass");
    end else begin
      $display("packet_header_field_extractor regression: fail");
    end
    $finish;
  end

endmodule
